/* rtl/aaf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package aaf_pkg;

   localparam int CMD_WIDTH  = 5;
   localparam int BYTE_WIDTH = 8;
   localparam int ACC_WIDTH  = 16;

   localparam logic [CMD_WIDTH-1:0] CMD_ADD  = 5'b11110;
   localparam logic [CMD_WIDTH-1:0] CMD_SUB  = 5'b11101;
   localparam logic [CMD_WIDTH-1:0] CMD_MUL  = 5'b11011;
   localparam logic [CMD_WIDTH-1:0] CMD_AND  = 5'b11010;
   localparam logic [CMD_WIDTH-1:0] CMD_OR   = 5'b11001;
   localparam logic [CMD_WIDTH-1:0] CMD_NOT  = 5'b11000;
   localparam logic [CMD_WIDTH-1:0] CMD_XOR  = 5'b10111;
   localparam logic [CMD_WIDTH-1:0] CMD_SHL  = 5'b10110;
   localparam logic [CMD_WIDTH-1:0] CMD_SHR  = 5'b10101;
   localparam logic [CMD_WIDTH-1:0] CMD_BRE  = 5'b10100;
   localparam logic [CMD_WIDTH-1:0] CMD_BRNE = 5'b10011;
   localparam logic [CMD_WIDTH-1:0] CMD_BRGT = 5'b10010;
   localparam logic [CMD_WIDTH-1:0] CMD_BRLT = 5'b10001;
   localparam logic [CMD_WIDTH-1:0] CMD_WACC = 5'b01001;
   localparam logic [CMD_WIDTH-1:0] CMD_RACC = 5'b01011;

   localparam logic [ACC_WIDTH-1:0] BYTE_MAX = 16'h00ff;
   localparam logic [ACC_WIDTH-1:0] SIGN_MIN = 16'h0080;

   // Result fields; last member sits in the lowest bits.
   typedef struct packed {
      logic                  bad_command;
      logic                  overflow_flag;
      logic                  sign_flag;
      logic                  carry_flag;
      logic                  zero_flag;
      logic [ACC_WIDTH-1:0]  acc_value;
      logic                  bus_drive;
      logic [BYTE_WIDTH-1:0] bus_out;
   } rsp_type;

   localparam int RSP_WIDTH  = $bits(rsp_type);
   localparam int RSP_TDATA_WIDTH = 32;
   localparam int REQ_TDATA_WIDTH = 16;

endpackage

`default_nettype wire

/* rtl/aaf_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

module aaf_alu (
   input  wire logic [aaf_pkg::CMD_WIDTH-1:0]  command,
   input  wire logic [aaf_pkg::BYTE_WIDTH-1:0] operand,
   input  wire logic [aaf_pkg::ACC_WIDTH-1:0]  acc_cur,
   output aaf_pkg::rsp_type                    result
);

   logic [aaf_pkg::ACC_WIDTH+aaf_pkg::BYTE_WIDTH-1:0] product;
   logic [aaf_pkg::ACC_WIDTH-1:0]                     acc_next;
   logic [aaf_pkg::BYTE_WIDTH-1:0]                    low_byte;
   logic                                              arith;
   logic                                              bad;
   logic                                              drive;

   assign product = acc_cur * operand;

   always_comb begin
      acc_next = acc_cur;
      low_byte = '0;
      arith    = 1'b1;
      bad      = 1'b0;
      drive    = 1'b0;
      case (command) inside
         aaf_pkg::CMD_ADD: begin
            low_byte = acc_cur[7:0] + operand;
            acc_next = {8'h00, low_byte};
         end
         aaf_pkg::CMD_SUB, aaf_pkg::CMD_BRE, aaf_pkg::CMD_BRNE,
         aaf_pkg::CMD_BRGT, aaf_pkg::CMD_BRLT: begin
            low_byte = acc_cur[7:0] - operand;
            acc_next = {8'h00, low_byte};
         end
         aaf_pkg::CMD_MUL: begin
            acc_next = product[aaf_pkg::ACC_WIDTH-1:0];
         end
         aaf_pkg::CMD_AND: begin
            acc_next = {8'h00, acc_cur[7:0] & operand};
         end
         aaf_pkg::CMD_OR: begin
            acc_next = {8'h00, acc_cur[7:0] | operand};
         end
         aaf_pkg::CMD_NOT: begin
            acc_next = {8'h00, ~acc_cur[7:0]};
         end
         aaf_pkg::CMD_XOR: begin
            acc_next = {8'h00, acc_cur[7:0] ^ operand};
         end
         aaf_pkg::CMD_SHL: begin
            acc_next = {8'h00, acc_cur[6:0], 1'b0};
         end
         aaf_pkg::CMD_SHR: begin
            // bit 8 of a wide product drops into bit 7
            acc_next = {8'h00, acc_cur[8:1]};
         end
         aaf_pkg::CMD_WACC: begin
            acc_next = {8'h00, operand};
            arith    = 1'b0;
         end
         aaf_pkg::CMD_RACC: begin
            low_byte = acc_cur[7:0];
            drive    = 1'b1;
            arith    = 1'b0;
         end
         default: begin
            bad   = 1'b1;
            arith = 1'b0;
         end
      endcase
   end

   always_comb begin
      result.bus_out       = drive ? low_byte : '0;
      result.bus_drive     = drive;
      result.acc_value     = acc_next;
      result.zero_flag     = arith && (acc_next == '0);
      result.carry_flag    = arith && (acc_next > aaf_pkg::BYTE_MAX);
      result.sign_flag     = arith && acc_next[7];
      result.overflow_flag = arith && (acc_next >= aaf_pkg::SIGN_MIN)
                                   && (acc_next < aaf_pkg::BYTE_MAX);
      result.bad_command   = bad;
   end

endmodule

`default_nettype wire

/* rtl/accumulator_alu_with_flags_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Path: an accepted request waits in the input register, then its result in the result
//   register, which holds it while rsp_tready is low.
// Throughput: one request per cycle while rsp_tready is high; the 16x8 multiply in the ALU sets the path.
// Reset: synchronous, active high; clears the accumulator and both valid bits.

module accumulator_alu_with_flags_core (
   input  wire logic        clock,
   input  wire logic        reset,

   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [4:0] command, [12:5] bus_in, [15:13] zero
   input  wire logic [aaf_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,

   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] bus_out, [8] bus_drive, [24:9] acc_value, [25] zero_flag,
   // [26] carry_flag, [27] sign_flag, [28] overflow_flag, [29] bad_command,
   // [31:30] zero
   output      logic [aaf_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   // input register
   logic                                 req_valid_ff;
   logic                                 req_valid_in;
   logic [aaf_pkg::CMD_WIDTH-1:0]        cmd_ff;
   logic [aaf_pkg::BYTE_WIDTH-1:0]       operand_ff;

   // accumulator: updated as a request moves into the result register
   logic [aaf_pkg::ACC_WIDTH-1:0]        acc_ff;
   logic [aaf_pkg::ACC_WIDTH-1:0]        acc_in;

   // result register
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   aaf_pkg::rsp_type                     rsp_ff;
   aaf_pkg::rsp_type                     alu_result;

   logic                                 req_take;
   logic                                 stage_go;

   // stage moves when the result register is empty or being drained
   assign stage_go   = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || stage_go;
   assign req_take   = req_tvalid && req_tready;

   aaf_alu u_alu (
      .command (cmd_ff),
      .operand (operand_ff),
      .acc_cur (acc_ff),
      .result  (alu_result)
   );

   always_comb begin
      req_valid_in = req_take || (req_valid_ff && !stage_go);
      rsp_valid_in = stage_go || (rsp_valid_ff && !rsp_tready);
      acc_in       = stage_go ? alu_result.acc_value : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff     <= req_tdata[aaf_pkg::CMD_WIDTH-1:0];
         operand_ff <= req_tdata[aaf_pkg::CMD_WIDTH +: aaf_pkg::BYTE_WIDTH];
      end
      if (stage_go) begin
         rsp_ff <= alu_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(aaf_pkg::RSP_TDATA_WIDTH-aaf_pkg::RSP_WIDTH){1'b0}}, rsp_ff};

   // a bad command never raises a flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.bad_command |->
         !(rsp_ff.zero_flag || rsp_ff.carry_flag || rsp_ff.sign_flag ||
           rsp_ff.overflow_flag || rsp_ff.bus_drive))
      else $error("flags set on bad command");

   // driven bus byte matches the accumulator left behind
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.bus_drive |->
         rsp_ff.bus_out == rsp_ff.acc_value[7:0])
      else $error("bus byte does not match accumulator");

   // carry excludes both overflow and zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.carry_flag |-> !rsp_ff.overflow_flag && !rsp_ff.zero_flag)
      else $error("carry with overflow or zero");

   // accumulator only changes when a request moves to the result register
   assert property (@(posedge clock) disable iff (reset)
      !stage_go |=> $stable(acc_ff))
      else $error("accumulator changed without a request");

   // the registered result follows the accumulator it wrote
   assert property (@(posedge clock) disable iff (reset)
      stage_go |=> rsp_valid_ff && (rsp_ff.acc_value == acc_ff))
      else $error("result and accumulator disagree");

endmodule

`default_nettype wire
